// ===== rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps
package rsd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COL_W     = 9;
	localparam int unsigned LIT_W     = 7;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_TDATA_W = 40;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd1;

	localparam logic [BYTE_W-1:0] RST_SPRITE_WIDTH  = 8'd8;
	localparam logic [BYTE_W-1:0] RST_SPRITE_HEIGHT = 8'd1;

	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_LIT  = 2'd1
	} phase_t;

	typedef struct packed {
		logic              write_enable;
		logic [BYTE_W-1:0] pixel_col;
		logic [BYTE_W-1:0] mirror_col;
		logic [BYTE_W-1:0] pixel_row;
		logic [BYTE_W-1:0] pixel_value;
		logic              row_end;
		logic              sprite_end;
		logic              overrun;
	} result_t;

endpackage

// ===== rtl/rsd_core.sv =====
`timescale 1ns / 1ps
module rsd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsd_pkg::BYTE_W-1:0]     cfg_data,
	input  logic                           accept,
	input  logic [rsd_pkg::BYTE_W-1:0]     data_byte,
	input  logic                           start_sprite,
	output rsd_pkg::result_t               res
);
	import rsd_pkg::*;

	logic [BYTE_W-1:0] sprite_width_q;
	logic [BYTE_W-1:0] sprite_height_q;

	phase_t            phase_q,        phase_d;
	logic [LIT_W-1:0]  literal_left_q, literal_left_d;
	logic [COL_W-1:0]  col_pos_q,      col_pos_d;
	logic [BYTE_W-1:0] row_pos_q,      row_pos_d;
	logic              finished_q,     finished_d;

	// State as seen by this byte, after an optional restart
	phase_t            cur_phase;
	logic [LIT_W-1:0]  cur_left;
	logic [COL_W-1:0]  cur_col;
	logic [BYTE_W-1:0] cur_row;
	logic              cur_finished;

	logic [COL_W-1:0]  padded;
	logic              in_pad;
	logic              ctrl_end;
	logic              last_row;
	logic [COL_W-1:0]  skip_len;
	logic [COL_W-1:0]  mirror_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_width_q  <= RST_SPRITE_WIDTH;
			sprite_height_q <= RST_SPRITE_HEIGHT;
		end else if (cfg_we) begin
			if (cfg_index == REG_SPRITE_WIDTH) begin
				sprite_width_q <= cfg_data;
			end else if (cfg_index == REG_SPRITE_HEIGHT) begin
				sprite_height_q <= cfg_data;
			end
		end
	end

	// Padded width: round width up to a multiple of 8 (up to 256)
	assign padded = ({1'b0, sprite_width_q} + COL_W'(7)) & ~COL_W'(7);

	always_comb begin
		if (start_sprite) begin
			cur_phase    = PH_CTRL;
			cur_left     = '0;
			cur_col      = '0;
			cur_row      = '0;
			cur_finished = 1'b0;
		end else begin
			cur_phase    = phase_q;
			cur_left     = literal_left_q;
			cur_col      = col_pos_q;
			cur_row      = row_pos_q;
			cur_finished = finished_q;
		end
	end

	assign in_pad      = cur_col < padded;
	assign ctrl_end    = (cur_col >= {1'b0, sprite_width_q}) || (data_byte == '0);
	assign last_row    = ({1'b0, cur_row} + 9'd1) >= {1'b0, sprite_height_q};
	assign skip_len    = 9'd256 - {1'b0, data_byte};
	assign mirror_full = padded - 9'd1 - cur_col;

	// Next state
	always_comb begin
		phase_d        = cur_phase;
		literal_left_d = cur_left;
		col_pos_d      = cur_col;
		row_pos_d      = cur_row;
		finished_d     = cur_finished;
		if (!cur_finished) begin
			if (cur_phase == PH_LIT) begin
				col_pos_d      = cur_col + 9'd1;
				literal_left_d = cur_left - LIT_W'(1);
				if (literal_left_d == '0) begin
					phase_d = PH_CTRL;
				end
			end else if (ctrl_end) begin
				col_pos_d      = '0;
				phase_d        = PH_CTRL;
				literal_left_d = '0;
				if (last_row) begin
					finished_d = 1'b1;
				end else begin
					row_pos_d = cur_row + 8'd1;
				end
			end else if (!data_byte[BYTE_W-1]) begin
				literal_left_d = data_byte[LIT_W-1:0];
				phase_d        = PH_LIT;
			end else begin
				col_pos_d = cur_col + skip_len;
			end
		end
	end

	// Result of this byte
	always_comb begin
		res = '0;
		if (!cur_finished) begin
			if (cur_phase == PH_LIT) begin
				if (in_pad) begin
					res.write_enable = 1'b1;
					res.pixel_col    = cur_col[BYTE_W-1:0];
					res.mirror_col   = mirror_full[BYTE_W-1:0];
					res.pixel_row    = cur_row;
					res.pixel_value  = data_byte;
				end else begin
					res.overrun = 1'b1;
				end
			end else if (ctrl_end) begin
				res.row_end    = 1'b1;
				res.sprite_end = last_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_CTRL;
			literal_left_q <= '0;
			col_pos_q      <= '0;
			row_pos_q      <= '0;
			finished_q     <= 1'b1;
		end else if (accept) begin
			phase_q        <= phase_d;
			literal_left_q <= literal_left_d;
			col_pos_q      <= col_pos_d;
			row_pos_q      <= row_pos_d;
			finished_q     <= finished_d;
		end
	end

`ifndef ASSERT_OFF
	a_lit_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LIT) |-> (literal_left_q != '0))
		else $error("literal phase with no literals left");
	a_end_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.sprite_end) |=> finished_q)
		else $error("sprite end did not stop decoding");
	a_write_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res.write_enable |-> (!res.row_end && !res.overrun))
		else $error("pixel write mixed with row end or overrun");
	a_sprite_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		res.sprite_end |-> res.row_end)
		else $error("sprite end without row end");
`endif

endmodule

// ===== rtl/rsd_out_reg.sv =====
`timescale 1ns / 1ps
module rsd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rsd_pkg::result_t res_in,
	output logic             space,
	output logic             valid,
	input  logic             ready,
	output rsd_pkg::result_t res_out
);
	import rsd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Room for a new beat when empty or when the held beat leaves this cycle
	assign space   = !valid_q || ready;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== rtl/rle_sprite_row_decoder.sv =====
`timescale 1ns / 1ps
// Run-length sprite row decoder. Takes one encoded sprite byte per beat on the
// s_ side and returns exactly one result beat per input beat on the m_ side,
// in the next cycle, at one beat per cycle while m_tready is high: the byte is
// decoded against the row/column counters in a single pass and the result
// lands in an output register, so a new byte is taken while the previous result
// is still waiting as long as m_tready drains it. Set s_tuser on the first
// control byte of a sprite to restart at row zero. Literal pixels produce a
// write at pixel_col and at mirror_col (padded width - 1 - column); literals at
// or past the padded width (width rounded up to a multiple of 8) are dropped and
// flagged as overrun. m_tlast marks the byte that closed a row. Bytes that
// arrive after the last row, until the next start, give an all-zero beat.
// sprite_width (index 0) and sprite_height (index 1) are written on the cfg_
// channel, which is always ready; write them only while the block is idle.
module rle_sprite_row_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsd_pkg::BYTE_W-1:0]    cfg_data,
	// encoded byte stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rsd_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] data_byte
	input  logic                          s_tuser,  // start_sprite
	// pixel results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] write_enable, [8:1] pixel_col, [16:9] mirror_col, [24:17] pixel_row,
	// [32:25] pixel_value, [33] sprite_end, [34] overrun, [39:35] zero
	output logic [rsd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast   // row_end
);
	import rsd_pkg::*;

	logic    accept;
	logic    space;
	result_t res_new;
	result_t res_held;

	assign cfg_ready = 1'b1;
	assign s_tready  = space;
	assign accept    = s_tvalid && space;

	rsd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.data_byte    (s_tdata),
		.start_sprite (s_tuser),
		.res          (res_new)
	);

	rsd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.res_in  (res_new),
		.space   (space),
		.valid   (m_tvalid),
		.ready   (m_tready),
		.res_out (res_held)
	);

	assign m_tdata = {5'd0, res_held.overrun, res_held.sprite_end,
		res_held.pixel_value, res_held.pixel_row, res_held.mirror_col,
		res_held.pixel_col, res_held.write_enable};
	assign m_tlast = res_held.row_end;

endmodule

// ===== tb/rle_sprite_row_decoder_test.sv =====
`timescale 1ns / 1ps
// Sprite row decoder test: directed streams for the corner cases, then random
// sprites over many width/height settings, a long output stall and a gap-free
// tail. Each accepted byte is run through a local decode model and the
// resulting beat is queued and compared against the m_ side in order.
module rle_sprite_row_decoder_test;
	import rsd_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int RANDOM_BYTES   = 400;  // decoded-byte mark that ends the random phase
	localparam int STEADY_BYTES   = 150;
	localparam int NO_CUT         = 1 << 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata = '0;   // [7:0] data_byte
	logic                 s_tuser = 1'b0; // start_sprite

	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // [0] we, [8:1] col, [16:9] mirror, [24:17] row,
	                                  // [32:25] value, [33] sprite_end, [34] overrun
	logic                   m_tlast;  // row_end

	rle_sprite_row_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Local copy of the decoder: registers and row/column walk.
	logic [BYTE_W-1:0] cfg_width  = RST_SPRITE_WIDTH;
	logic [BYTE_W-1:0] cfg_height = RST_SPRITE_HEIGHT;
	phase_t            dec_phase  = PH_CTRL;
	logic [LIT_W-1:0]  lit_left   = '0;
	logic [COL_W-1:0]  col_pos    = '0;
	logic [BYTE_W-1:0] row_pos    = '0;
	logic              dec_done   = 1'b1;  // idle until a start beat

	result_t pixel_q[$];  // expected result beats, oldest first

	bit tx_gaps_on  = 1'b0;
	bit rx_gaps_on  = 1'b0;
	int rx_hold_len = 0;  // one-shot long stall request for the result side

	int n_errors = 0;
	int bytes_decoded = 0;
	int beats_checked = 0;
	int n_writes = 0;
	int n_overruns = 0;
	int n_rows = 0;
	int n_sprites = 0;
	int n_settings = 0;
	int stall_cycles = 0;
	int cycle_cnt = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop in case the DUT hangs the handshake.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (s_tvalid && !s_tready)
			stall_cycles <= stall_cycles + 1;
		if (cycle_cnt == TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, pixel_q.size());
			$display("** rle_sprite_row_decoder: FAILED **");
			$finish;
		end
	end

	// Decode one accepted byte; returns the beat the block should emit for it.
	function automatic result_t decode_byte(input logic [7:0] b, input logic st);
		result_t r;
		logic [COL_W-1:0] padded;
		r = '0;
		padded = ({1'b0, cfg_width} + 9'd7) & ~9'd7;
		if (st) begin
			dec_phase = PH_CTRL;
			lit_left = '0;
			col_pos = '0;
			row_pos = '0;
			dec_done = 1'b0;
		end
		if (dec_done)
			return r;  // ignored byte, all-zero beat
		bytes_decoded++;
		if (dec_phase == PH_LIT) begin
			if (col_pos < padded) begin
				r.write_enable = 1'b1;
				r.pixel_col = col_pos[7:0];
				r.mirror_col = 8'(padded - 9'd1 - col_pos);
				r.pixel_row = row_pos;
				r.pixel_value = b;
				n_writes++;
			end else begin
				// past padded width: dropped, column still moves
				r.overrun = 1'b1;
				n_overruns++;
			end
			col_pos = col_pos + 9'd1;
			lit_left = lit_left - 7'd1;
			if (lit_left == '0)
				dec_phase = PH_CTRL;
		end else if (col_pos >= {1'b0, cfg_width} || b == 8'h00) begin
			// row done: explicit zero or width reached (byte value ignored)
			r.row_end = 1'b1;
			n_rows++;
			col_pos = '0;
			lit_left = '0;
			dec_phase = PH_CTRL;
			if ({1'b0, row_pos} + 9'd1 >= {1'b0, cfg_height}) begin
				r.sprite_end = 1'b1;
				dec_done = 1'b1;
				n_sprites++;
			end else begin
				row_pos = row_pos + 8'd1;
			end
		end else if (!b[7]) begin
			lit_left = b[6:0];
			dec_phase = PH_LIT;
		end else begin
			col_pos = col_pos + (9'd256 - {1'b0, b});  // transparent skip
		end
		return r;
	endfunction

	function automatic void check_field(input string fname, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= 40)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
		end
	endfunction

	// Result checker: every accepted m_ beat against the oldest expectation.
	always @(posedge clk) begin : check_beats
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 40)
					$display("%0t ns: result beat with none expected, expected nothing, got %h/%b",
						$time, m_tdata, m_tlast);
			end else begin
				want = pixel_q.pop_front();
				beats_checked++;
				check_field("write_enable", 8'(want.write_enable), 8'(m_tdata[0]));
				check_field("pixel_col", want.pixel_col, m_tdata[8:1]);
				check_field("mirror_col", want.mirror_col, m_tdata[16:9]);
				check_field("pixel_row", want.pixel_row, m_tdata[24:17]);
				check_field("pixel_value", want.pixel_value, m_tdata[32:25]);
				check_field("row_end", 8'(want.row_end), 8'(m_tlast));
				check_field("sprite_end", 8'(want.sprite_end), 8'(m_tdata[33]));
				check_field("overrun", 8'(want.overrun), 8'(m_tdata[34]));
				check_field("tdata padding", 8'd0, {3'b000, m_tdata[39:35]});
			end
		end
	end

	// Result-side ready: random stall bursts, plus one long hold on request.
	initial begin : drive_ready
		@(posedge clk);
		forever begin
			if (rx_hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// One input beat. Valid stays high afterwards so back-to-back beats need no gap.
	task automatic send_byte(input logic [7:0] b, input logic st);
		if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		pixel_q.push_back(decode_byte(b, st));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write both registers back to back; only called with the stream drained.
	task automatic configure(input logic [7:0] w, input logic [7:0] h);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_SPRITE_WIDTH;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_width = w;
		cfg_index <= REG_SPRITE_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_height = h;
		cfg_valid <= 1'b0;
		n_settings++;
		repeat (2) @(posedge clk);
	endtask

	// Well-formed sprite with random runs; cut stops early so the next start
	// abandons it. Literal runs sometimes overshoot the width to hit overrun.
	task automatic send_sprite(input int cut);
		int rows;
		int col;
		int n;
		int room;
		int k;
		int sent;
		logic first;
		rows = (cfg_height == 0) ? 1 : int'(cfg_height);
		first = 1'b1;
		sent = 0;
		for (int r = 0; r < rows; r++) begin
			col = 0;
			forever begin
				if (sent >= cut)
					return;
				if (col >= int'(cfg_width)) begin
					send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), first);
					first = 1'b0;
					sent++;
					break;
				end
				room = int'(cfg_width) - col;
				k = $urandom_range(0, 9);
				if (k == 0) begin
					send_byte(8'h00, first);  // early end of row
					first = 1'b0;
					sent++;
					break;
				end else if (k <= 3) begin
					if ($urandom_range(0, 4) == 0)
						n = $urandom_range(1, 128);
					else
						n = $urandom_range(1, (room > 128) ? 128 : room);
					send_byte(8'(256 - n), first);
					first = 1'b0;
					sent++;
					col += n;
				end else begin
					if ($urandom_range(0, 3) == 0)
						room += $urandom_range(1, 9);
					if (room > 127)
						room = 127;
					n = $urandom_range(1, room);
					send_byte(8'(n), first);
					first = 1'b0;
					repeat (n) send_byte(8'($urandom), 1'b0);
					sent += n + 1;
					col += n;
				end
			end
		end
	endtask

	// Reset values (width 8, height 1): ignored byte, literals, skip, width stop.
	task automatic test_reset_values();
		send_byte(8'h2A, 1'b0);  // idle before any start
		send_byte(8'h03, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFE, 1'b0);  // skip 2
		send_byte(8'h03, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h77, 1'b0);  // width reached: row and sprite end
		send_byte(8'h00, 1'b0);  // after the last row: ignored
	endtask

	// Padded width 8 on width 5: overrun, full skip, zero terminator.
	task automatic test_row_cases();
		configure(8'd5, 8'd3);
		send_byte(8'h0A, 1'b1);
		repeat (10) send_byte(8'($urandom), 1'b0);  // cols 8 and 9 overrun
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);  // skip 128, past the width
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// Restart in the middle, zero width and zero height.
	task automatic test_restart_and_degenerate();
		configure(8'd16, 8'd4);
		send_byte(8'h04, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h02, 1'b1);  // start lands where a literal was due
		send_byte(8'h33, 1'b0);
		send_byte(8'h44, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		configure(8'd0, 8'd2);
		send_byte(8'h05, 1'b1);  // zero width: any control ends the row
		send_byte(8'h80, 1'b0);
		configure(8'd3, 8'd0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h00, 1'b0);  // zero height: first row ends the sprite
	endtask

	// New width takes effect on the next byte of a sprite already under way.
	task automatic test_register_change_mid_sprite();
		configure(8'd16, 8'd2);
		send_byte(8'h04, 1'b1);
		repeat (4) send_byte(8'($urandom), 1'b0);
		configure(8'd3, 8'd2);
		send_byte(8'h11, 1'b0);  // col 4 >= 3: row end
		configure(8'd255, 8'd2);
		send_byte(8'h02, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_random_sprites();
		int w;
		int h;
		int k;
		while (bytes_decoded < RANDOM_BYTES) begin
			k = $urandom_range(0, 19);
			if (k < 12)
				w = $urandom_range(1, 24);
			else if (k < 15)
				w = $urandom_range(25, 64);
			else if (k < 17)
				w = 255;
			else if (k < 18)
				w = 0;
			else
				w = $urandom_range(240, 254);
			k = $urandom_range(0, 9);
			h = (k == 0) ? 0 : (k < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
			configure(8'(w), 8'(h));
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 4)) begin
				if (bytes_decoded >= RANDOM_BYTES)
					break;
				k = $urandom_range(0, 9);
				if (k == 0)
					repeat ($urandom_range(4, 16))
						send_byte(8'($urandom), $urandom_range(0, 7) == 0);
				else if (k == 1)
					send_sprite($urandom_range(1, 8));
				else
					send_sprite(NO_CUT);
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	// Result side held off for a long stretch while bytes keep coming.
	task automatic test_backpressure();
		configure(8'd24, 8'd3);
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		rx_hold_len = 200;
		send_sprite(NO_CUT);
		send_sprite(NO_CUT);
	endtask

	task automatic test_extreme_sizes();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		configure(8'd255, 8'd1);
		send_sprite(NO_CUT);
		configure(8'd1, 8'd255);
		send_sprite(NO_CUT);
	endtask

	// Last part: no idling on either side.
	task automatic test_steady_stream();
		int mark;
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		configure(8'($urandom_range(1, 16)), 8'($urandom_range(1, 4)));
		mark = bytes_decoded + STEADY_BYTES;
		while (bytes_decoded < mark)
			send_sprite(($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : NO_CUT);
	endtask

	initial begin : run
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_row_cases();
		test_restart_and_degenerate();
		test_register_change_mid_sprite();
		test_random_sprites();
		test_backpressure();
		test_extreme_sizes();
		test_steady_stream();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d decoded bytes in %0d checked beats: %0d pixel writes, %0d overruns,",
			bytes_decoded, beats_checked, n_writes, n_overruns);
		$display("%0d rows, %0d sprites over %0d width/height settings; input stalled %0d cycles.",
			n_rows, n_sprites, n_settings, stall_cycles);
		if (n_errors == 0 && pixel_q.size() == 0) begin
			$display("** rle_sprite_row_decoder: PASSED **");
		end else begin
			$display("%0d mismatches, %0d beats never arrived", n_errors, pixel_q.size());
			$display("** rle_sprite_row_decoder: FAILED **");
		end
		$finish;
	end

endmodule

// ===== rle_sprite_row_decoder.f =====
rtl/rsd_pkg.sv
rtl/rsd_core.sv
rtl/rsd_out_reg.sv
rtl/rle_sprite_row_decoder.sv
tb/rle_sprite_row_decoder_test.sv
